### rtl/core/pipc_pkg.sv
// ----------------------------------------------------------------------------
// pipc_pkg: shared types and constants
// Beat formats and codes for the point in polygon crossing block.
// ----------------------------------------------------------------------------
package pipc_pkg;

    localparam int COORD_W  = 24;
    localparam int IDX_W    = 4;
    localparam int CNT_W    = 5;

    localparam logic [CNT_W-1:0] CFG_COUNT_RESET = 5'd4;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic                      op;
        logic [IDX_W-1:0]          vertex_index;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
    } t_cmd;

    typedef struct packed {
        logic             inside_res;
        logic [CNT_W-1:0] crossings;
    } t_res;

endpackage

### rtl/core/pipc_ram.sv
// ----------------------------------------------------------------------------
// pipc_ram: generic dual-address RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module pipc_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/point_in_polygon_crossing.sv
// ----------------------------------------------------------------------------
// point_in_polygon_crossing: ray cast point in polygon test
// Holds polygon vertices in a RAM and counts crossings of a ray toward +x.
// ----------------------------------------------------------------------------
//  channel   direction  handshake                 beat
//  command   in         start & !busy             t_cmd (op, index, x, y)
//  result    out        o_res_valid, one cycle    t_res (inside, crossings)
//  config    in         i_cfg_valid & o_cfg_ready vertex count, 5 bits
//
//  a vertex write leaves busy low. a query with n > 0 vertices in use keeps
//  busy high while the single RAM read port walks the vertices one per cycle
//  into a three stage edge evaluator.
//  the result strobe follows the last busy cycle; the next command can be
//  taken in that same cycle. synchronous active-low reset sets the vertex
//  count to 4; the vertex RAM is not cleared. the receiver cannot stall.
// ----------------------------------------------------------------------------
module point_in_polygon_crossing #(
    parameter int MAX_VERTICES = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  pipc_pkg::t_cmd      i_cmd,
    output logic                o_res_valid,
    output pipc_pkg::t_res      o_res,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [pipc_pkg::CNT_W-1:0] i_cfg_data
);

    localparam int CW  = pipc_pkg::COORD_W;
    localparam int DW  = CW + 1;
    localparam int PW  = 2 * DW;
    localparam int AW  = $clog2(MAX_VERTICES);
    localparam int NW0 = $clog2(MAX_VERTICES + 1);
    localparam int NW  = (NW0 > pipc_pkg::CNT_W) ? NW0 : pipc_pkg::CNT_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_WAIT,
        S_CLOSE,
        S_DRAIN
    } t_state;

    t_state r_state;

    logic [pipc_pkg::CNT_W-1:0] r_vertex_count;
    logic [NW-1:0]              r_n;
    logic [NW-1:0]              r_cross;
    logic [AW-1:0]              r_addr;
    logic [AW-1:0]              r_didx;
    logic                       r_dv;
    logic signed [CW-1:0]       r_px, r_py;
    logic signed [CW-1:0]       r_prev_x, r_prev_y;
    logic signed [CW-1:0]       r_first_x, r_first_y;

    logic                       r_s1_v, r_s1_hit;
    logic signed [DW-1:0]       r_t, r_dx, r_u, r_dy;
    logic                       r_s2_v, r_s2_hit;
    logic signed [PW-1:0]       r_p1, r_p2;

    logic                       r_res_valid;
    pipc_pkg::t_res             r_res;

    logic                       accept;
    logic                       wr_in_range;
    logic                       ram_we;
    logic [AW-1:0]              ram_waddr;
    logic [2*CW-1:0]            ram_rdata;
    logic [NW-1:0]              n_use;
    logic signed [CW-1:0]       rd_x, rd_y;

    logic                       edge_v;
    logic signed [CW-1:0]       ax, ay, bx, by;
    logic signed [CW-1:0]       lo_x, lo_y, hi_x, hi_y;
    logic                       swap_ab;
    logic                       edge_hit;

    assign busy        = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    assign wr_in_range = (32'(i_cmd.vertex_index) < 32'(MAX_VERTICES));
    assign ram_we      = accept && (i_cmd.op == pipc_pkg::OP_WRITE) && wr_in_range;
    assign ram_waddr   = AW'(i_cmd.vertex_index);

    assign n_use = (32'(r_vertex_count) >= 32'(MAX_VERTICES)) ? NW'(MAX_VERTICES)
                                                              : NW'(r_vertex_count);

    pipc_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_VERTICES)
    ) u_vtx_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata ({i_cmd.point_x, i_cmd.point_y}),
        .i_raddr (r_addr),
        .o_rdata (ram_rdata)
    );

    assign rd_x = ram_rdata[2*CW-1:CW];
    assign rd_y = ram_rdata[CW-1:0];

    // edge source: walking pair, or closing edge back to vertex 0
    always_comb begin
        edge_v = (r_dv && (r_didx != '0)) || (r_state == S_CLOSE);
        ax = r_prev_x;
        ay = r_prev_y;
        bx = (r_state == S_CLOSE) ? r_first_x : rd_x;
        by = (r_state == S_CLOSE) ? r_first_y : rd_y;
        swap_ab = (ay > by);
        lo_x = swap_ab ? bx : ax;
        lo_y = swap_ab ? by : ay;
        hi_x = swap_ab ? ax : bx;
        hi_y = swap_ab ? ay : by;
        edge_hit = (ay != by) && (r_py >= lo_y) && (r_py < hi_y);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_vertex_count <= pipc_pkg::CFG_COUNT_RESET;
            r_dv           <= 1'b0;
            r_s1_v         <= 1'b0;
            r_s2_v         <= 1'b0;
            r_res_valid    <= 1'b0;
            r_cross        <= '0;
            r_n            <= '0;
            r_addr         <= '0;
        end else begin
            r_res_valid <= (r_state == S_DRAIN) && !r_s1_v && !r_s2_v;
            r_dv        <= (r_state == S_READ);
            r_didx      <= r_addr;

            if (i_cfg_valid && o_cfg_ready) begin
                r_vertex_count <= i_cfg_data;
            end

            // vertex walk
            if (r_dv) begin
                r_prev_x <= rd_x;
                r_prev_y <= rd_y;
                if (r_didx == '0) begin
                    r_first_x <= rd_x;
                    r_first_y <= rd_y;
                end
            end

            // edge stage: order endpoints, range test, differences
            r_s1_v   <= edge_v;
            r_s1_hit <= edge_hit;
            r_t      <= DW'(r_py) - DW'(lo_y);
            r_dx     <= DW'(hi_x) - DW'(lo_x);
            r_u      <= DW'(r_px) - DW'(lo_x);
            r_dy     <= DW'(hi_y) - DW'(lo_y);

            // product stage
            r_s2_v   <= r_s1_v;
            r_s2_hit <= r_s1_hit;
            r_p1     <= r_t * r_dx;
            r_p2     <= r_u * r_dy;

            // compare and count
            if (r_s2_v && r_s2_hit && (r_p1 > r_p2)) begin
                r_cross <= r_cross + NW'(1);
            end

            unique case (r_state)
                S_IDLE: begin
                    if (accept && (i_cmd.op == pipc_pkg::OP_QUERY)) begin
                        r_px    <= i_cmd.point_x;
                        r_py    <= i_cmd.point_y;
                        r_cross <= '0;
                        r_n     <= n_use;
                        r_addr  <= '0;
                        r_state <= (n_use == '0) ? S_DRAIN : S_READ;
                    end
                end
                S_READ: begin
                    if (NW'(r_addr) == r_n - NW'(1)) begin
                        r_state <= S_WAIT;
                    end else begin
                        r_addr <= r_addr + AW'(1);
                    end
                end
                S_WAIT: begin
                    r_state <= S_CLOSE;
                end
                S_CLOSE: begin
                    r_state <= S_DRAIN;
                end
                S_DRAIN: begin
                    if (!r_s1_v && !r_s2_v) begin
                        r_res.inside_res     <= r_cross[0];
                        r_res.crossings      <= r_cross[pipc_pkg::CNT_W-1:0];
                        r_state              <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

`ifndef ASSERT_OFF
    a_strobe_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> ($past(r_state) == S_DRAIN && r_state == S_IDLE))
        else $error("result strobe without a finished query");

    a_idle_pipe_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> (!r_s1_v && !r_s2_v && !r_dv))
        else $error("edge pipeline active while idle");

    a_cross_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cross <= r_n))
        else $error("crossing count exceeds edge count");

    a_query_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.op == pipc_pkg::OP_QUERY) |=> busy)
        else $error("query accepted without going busy");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_cmd.op == pipc_pkg::OP_WRITE) |=> (!busy && !o_res_valid))
        else $error("vertex write produced work or a result");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: point in polygon crossing block
// A probe table first checks a full-range square by hand-derived answers,
// then random polygons with queries near edges and vertices run at several
// vertex counts and pacing levels. All other results are compared against a
// ray-cast predictor kept in step with the vertex writes.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD     = 10;
    localparam int MAX_VERTS      = 16;
    localparam int RESET_CYCLES   = 8;
    localparam int SETTLE_CYCLES  = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_ITEMS    = 80;
    localparam int NUM_PHASES     = 9;
    localparam int PROBE_ROWS     = 19;

    localparam logic signed [pipc_pkg::COORD_W-1:0] C_MIN = 24'sh800000;
    localparam logic signed [pipc_pkg::COORD_W-1:0] C_MAX = 24'sh7FFFFF;

    localparam pipc_pkg::t_res NO_RES  = '0;
    localparam pipc_pkg::t_res RES_OUT = '{1'b0, 5'd0};
    localparam pipc_pkg::t_res RES_IN1 = '{1'b1, 5'd1};

    typedef enum int {SPREAD_FULL, SPREAD_LOCAL, SPREAD_GRID} t_spread;

    typedef struct packed {
        logic                                op;
        logic [pipc_pkg::IDX_W-1:0]          idx;
        logic signed [pipc_pkg::COORD_W-1:0] x;
        logic signed [pipc_pkg::COORD_W-1:0] y;
        logic                                known;
        pipc_pkg::t_res                      res;
    } t_probe_row;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       start       = 1'b0;
    logic                       busy;
    pipc_pkg::t_cmd             i_cmd       = '0;
    logic                       o_res_valid;
    pipc_pkg::t_res             o_res;
    logic                       i_cfg_valid = 1'b0;
    logic                       o_cfg_ready;
    logic [pipc_pkg::CNT_W-1:0] i_cfg_data  = '0;

    logic signed [pipc_pkg::COORD_W-1:0] poly_x [MAX_VERTS];
    logic signed [pipc_pkg::COORD_W-1:0] poly_y [MAX_VERTS];
    logic [MAX_VERTS-1:0]                vertex_written = '0;
    logic [pipc_pkg::CNT_W-1:0]          model_count    = pipc_pkg::CFG_COUNT_RESET;

    pipc_pkg::t_res expected_results [$];
    int   idle_pct        = 0;
    int   commands_sent   = 0;
    int   results_checked = 0;
    int   mismatches      = 0;
    int   stall_cycles    = 0;

    t_probe_row probe_table [PROBE_ROWS] = '{
        '{pipc_pkg::OP_WRITE, 4'd0,  C_MIN,        C_MIN,        1'b0, NO_RES},
        '{pipc_pkg::OP_WRITE, 4'd1,  C_MAX,        C_MIN,        1'b0, NO_RES},
        '{pipc_pkg::OP_WRITE, 4'd2,  C_MAX,        C_MAX,        1'b0, NO_RES},
        '{pipc_pkg::OP_WRITE, 4'd3,  C_MIN,        C_MAX,        1'b0, NO_RES},
        '{pipc_pkg::OP_QUERY, 4'd0,  24'sh000000,  24'sh000000,  1'b1, RES_IN1},
        '{pipc_pkg::OP_QUERY, 4'd15, C_MIN,        C_MIN,        1'b1, RES_IN1},
        '{pipc_pkg::OP_QUERY, 4'd5,  C_MAX,        C_MAX,        1'b1, RES_OUT},
        '{pipc_pkg::OP_QUERY, 4'd10, C_MAX,        24'sh000000,  1'b1, RES_OUT},
        '{pipc_pkg::OP_QUERY, 4'd0,  24'sh7FFFFE,  24'sh000000,  1'b1, RES_IN1},
        '{pipc_pkg::OP_QUERY, 4'd0,  C_MIN,        24'sh000000,  1'b1, RES_IN1},
        '{pipc_pkg::OP_QUERY, 4'd0,  24'sh000000,  24'sh7FFFFE,  1'b1, RES_IN1},
        '{pipc_pkg::OP_WRITE, 4'd2,  24'sh000000,  C_MAX,        1'b0, NO_RES},
        '{pipc_pkg::OP_QUERY, 4'd0,  24'sh3D0900,  24'sh3D0900,  1'b0, NO_RES},
        '{pipc_pkg::OP_QUERY, 4'd0,  24'shFFFFFF,  24'shFFFFFF,  1'b0, NO_RES},
        '{pipc_pkg::OP_WRITE, 4'd0,  24'sh000000,  24'sh000000,  1'b0, NO_RES},
        '{pipc_pkg::OP_QUERY, 4'd0,  24'sh000100,  24'sh000100,  1'b0, NO_RES},
        '{pipc_pkg::OP_QUERY, 4'd0,  C_MAX,        24'sh000000,  1'b0, NO_RES},
        '{pipc_pkg::OP_WRITE, 4'd15, 24'sh555555,  24'shAAAAAA,  1'b0, NO_RES},
        '{pipc_pkg::OP_QUERY, 4'd15, 24'shAAAAAA,  24'sh555555,  1'b0, NO_RES}
    };

    int unsigned phase_counts [NUM_PHASES] = '{3, 16, 0, 1, 2, 31, 17, 5, 0};

    point_in_polygon_crossing #(
        .MAX_VERTICES (MAX_VERTS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_cmd       (i_cmd),
        .o_res_valid (o_res_valid),
        .o_res       (o_res),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic pipc_pkg::t_res ray_cast(logic signed [pipc_pkg::COORD_W-1:0] qx,
                                                logic signed [pipc_pkg::COORD_W-1:0] qy);
        pipc_pkg::t_res r;
        int     n;
        int     j;
        int     hits;
        longint px, py, xa, ya, xb, yb, t;
        n    = (model_count < MAX_VERTS) ? int'(model_count) : MAX_VERTS;
        hits = 0;
        px   = longint'(qx);
        py   = longint'(qy);
        for (int i = 0; i < n; i++) begin
            j  = (i + 1 == n) ? 0 : i + 1;
            xa = longint'(poly_x[i]);
            ya = longint'(poly_y[i]);
            xb = longint'(poly_x[j]);
            yb = longint'(poly_y[j]);
            if (ya == yb)
                continue;
            if (ya > yb) begin
                t = xa; xa = xb; xb = t;
                t = ya; ya = yb; yb = t;
            end
            if (py < ya || py >= yb)
                continue;
            if ((py - ya) * (xb - xa) > (px - xa) * (yb - ya))
                hits++;
        end
        r.inside_res = hits[0];
        r.crossings  = hits[pipc_pkg::CNT_W-1:0];
        return r;
    endfunction

    function automatic pipc_pkg::t_cmd make_cmd(logic op, logic [pipc_pkg::IDX_W-1:0] idx,
                                                logic signed [pipc_pkg::COORD_W-1:0] x,
                                                logic signed [pipc_pkg::COORD_W-1:0] y);
        pipc_pkg::t_cmd c;
        c.op           = op;
        c.vertex_index = idx;
        c.point_x      = x;
        c.point_y      = y;
        return c;
    endfunction

    function automatic logic signed [pipc_pkg::COORD_W-1:0] rand_coord(t_spread sp);
        int v;
        case (sp)
            SPREAD_LOCAL: v = int'($urandom_range(0, 8191)) - 4096;
            SPREAD_GRID:  v = (int'($urandom_range(0, 6)) - 3) * 256;
            default:      v = int'($urandom);
        endcase
        return pipc_pkg::COORD_W'(v);
    endfunction

    function automatic void check_result(pipc_pkg::t_res want, pipc_pkg::t_res got);
        if (got.inside_res !== want.inside_res) begin
            $error("inside_res mismatch: expected %0d, got %0d",
                   want.inside_res, got.inside_res);
            mismatches++;
        end
        if (got.crossings !== want.crossings) begin
            $error("crossings mismatch: expected %0d, got %0d",
                   want.crossings, got.crossings);
            mismatches++;
        end
    endfunction

    task automatic send_cmd(input pipc_pkg::t_cmd c, input logic known,
                            input pipc_pkg::t_res known_res);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = $urandom_range(1, 20);
            repeat (gap) begin
                @(negedge i_clk);
                start <= 1'b0;
            end
        end
        @(negedge i_clk);
        start <= 1'b1;
        i_cmd <= c;
        do @(posedge i_clk); while (busy);
        commands_sent++;
        if (c.op == pipc_pkg::OP_WRITE) begin
            poly_x[c.vertex_index]         = c.point_x;
            poly_y[c.vertex_index]         = c.point_y;
            vertex_written[c.vertex_index] = 1'b1;
        end else begin
            expected_results.insert(expected_results.size(),
                                    known ? known_res : ray_cast(c.point_x, c.point_y));
        end
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        start <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_vertex_count(input logic [pipc_pkg::CNT_W-1:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        model_count = value;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random_phase(input int target);
        int                                  done_at;
        int                                  nuse;
        int                                  nq;
        int                                  pick;
        int                                  v;
        logic                                loaded;
        t_spread                             sp;
        logic signed [pipc_pkg::COORD_W-1:0] qx, qy;
        nuse    = (model_count < MAX_VERTS) ? int'(model_count) : MAX_VERTS;
        done_at = commands_sent + target;
        while (commands_sent < done_at) begin
            if ($urandom_range(0, 9) < 8) begin
                sp = t_spread'($urandom_range(0, 2));
                for (int k = 0; k < nuse; k++)
                    send_cmd(make_cmd(pipc_pkg::OP_WRITE, pipc_pkg::IDX_W'(k),
                                      rand_coord(sp), rand_coord(sp)),
                             1'b0, NO_RES);
                nq = $urandom_range(2, 8);
                repeat (nq) begin
                    pick = $urandom_range(0, 3);
                    v    = (nuse > 0) ? $urandom_range(0, nuse - 1) : 0;
                    qx   = rand_coord(sp);
                    qy   = rand_coord(sp);
                    if (nuse > 0 && pick == 1) begin
                        qx = poly_x[v];
                        qy = poly_y[v];
                    end else if (nuse > 0 && pick == 2) begin
                        qy = poly_y[v];
                    end else if (pick == 3) begin
                        qx = rand_coord(SPREAD_FULL);
                        qy = rand_coord(SPREAD_FULL);
                    end
                    send_cmd(make_cmd(pipc_pkg::OP_QUERY, pipc_pkg::IDX_W'($urandom), qx, qy),
                             1'b0, NO_RES);
                end
            end else begin
                loaded = 1'b1;
                for (int k = 0; k < nuse; k++)
                    if (!vertex_written[k])
                        loaded = 1'b0;
                // stray beat: a lone query or a lone vertex overwrite
                send_cmd(make_cmd((loaded && $urandom_range(0, 1)) ? pipc_pkg::OP_QUERY
                                                                   : pipc_pkg::OP_WRITE,
                                  pipc_pkg::IDX_W'($urandom), rand_coord(SPREAD_FULL),
                                  rand_coord(SPREAD_FULL)),
                         1'b0, NO_RES);
            end
            if ($urandom_range(0, 29) == 0)
                drain_results();
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_res_valid) begin
            if (expected_results.size() == 0) begin
                $error("result beat with no query pending: inside_res %0d, crossings %0d",
                       o_res.inside_res, o_res.crossings);
                mismatches++;
            end else begin
                check_result(expected_results.pop_front(), o_res);
                results_checked++;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && !busy) || o_res_valid || (i_cfg_valid && o_cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        idle_pct = 15;
        for (int r = 0; r < PROBE_ROWS; r++)
            send_cmd(make_cmd(probe_table[r].op, probe_table[r].idx,
                              probe_table[r].x, probe_table[r].y),
                     probe_table[r].known, probe_table[r].res);

        for (int p = 0; p < NUM_PHASES; p++) begin
            idle_pct = (p < 3) ? 15 : (p < 6) ? 49 : 0;
            set_vertex_count((p == NUM_PHASES - 1)
                             ? pipc_pkg::CNT_W'($urandom_range(3, 16))
                             : pipc_pkg::CNT_W'(phase_counts[p]));
            run_random_phase(PHASE_ITEMS);
        end

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("%0d command beats sent, %0d query results checked, %0d mismatches",
                 commands_sent, results_checked, mismatches);
        $display("covered vertex counts 0 to 31, full-range and near-vertex queries");
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
